>>> src/lcar_pkg.sv
// ----------------------------------------------------------------------------
// lcar_pkg
// shared constants, types and codes for the load cell converter reader
// ----------------------------------------------------------------------------
package lcar_pkg;

    localparam int MAX_AVERAGE = 256;
    localparam int SAMPLE_BITS = 24;

    localparam int AVG_W    = 9;
    localparam int GAIN_W   = 5;
    localparam int SCALE_W  = 32;
    localparam int NET_W    = 25;
    localparam int UNITS_W  = 40;
    localparam int ROUND_SH = 16;
    localparam int IDX_W    = 2;

    localparam int COUNT_W   = $clog2(MAX_AVERAGE + 1);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_AVERAGE);
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int DIFF_W    = SUM_W + 1;
    localparam int PROD_W    = DIFF_W + SCALE_W;

    localparam logic [GAIN_W-1:0] PULSES_MIN = GAIN_W'(25);
    localparam logic [GAIN_W-1:0] PULSES_MAX = GAIN_W'(27);

    localparam logic [IDX_W-1:0] REG_AVERAGE_COUNT    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_GAIN_PULSES      = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_RECIPROCAL_SCALE = IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MEAN,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic tick;
        logic div_step;
        logic mean;
        logic mult;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic need_mean;
        logic div_last;
        logic tare_mean;
    } dp_status_t;

endpackage

>>> src/load_cell_adc_reader_core.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader_core
// two-wire load cell converter reader with averaging, tare and scaling
// ----------------------------------------------------------------------------
// channel  handshake              payload
// in       in_valid / in_ready    data_level, tare_request
// out      out_valid / out_ready  clock_level, result_valid, net_counts,
//                                 scaled_units, tare_done
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item is one serial clock half-period and gives one result item
// a tick that completes no mean goes from idle straight to ST_OUT
// a completing tick runs the restoring divider in ST_DIV, then ST_MEAN,
// then for a mean that is not a tare mean the scaling multiply in ST_MUL,
// then ST_OUT, which loads the output register once it is empty or its
// result is being taken
// in_ready is high only while the sequencer is idle; a result held in the
// output register does not block the next item, only its handoff
// reset clears all control and averaging state, cfg_ready is always high
// ----------------------------------------------------------------------------
module load_cell_adc_reader_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                data_level,
    input  logic                                tare_request,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                clock_level,
    output logic                                result_valid,
    output logic signed [lcar_pkg::NET_W-1:0]   net_counts,
    output logic signed [lcar_pkg::UNITS_W-1:0] scaled_units,
    output logic                                tare_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcar_pkg::IDX_W-1:0]          cfg_index,
    input  logic [lcar_pkg::SCALE_W-1:0]        cfg_data
);
    import lcar_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    lcar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcar_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .data_level   (data_level),
        .tare_request (tare_request),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .clock_level  (clock_level),
        .result_valid (result_valid),
        .net_counts   (net_counts),
        .scaled_units (scaled_units),
        .tare_done    (tare_done)
    );

endmodule

>>> src/lcar_ctrl.sv
// ----------------------------------------------------------------------------
// lcar_ctrl
// sequencer: tick, mean division, offset or scaling, output handoff
// ----------------------------------------------------------------------------
module lcar_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lcar_pkg::dp_status_t status,
    output lcar_pkg::dp_cmd_t    cmd
);
    import lcar_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   load_ok;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign load_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.need_mean ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                state_next = status.tare_mean ? ST_OUT : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.tick = in_valid;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_MEAN:
            begin
                cmd.mean = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mult = 1'b1;
            end
            ST_OUT:
            begin
                cmd.load_out = load_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/lcar_datapath.sv
// ----------------------------------------------------------------------------
// lcar_datapath
// serial capture, sample sum, restoring divider, offset, scaling, output regs
// ----------------------------------------------------------------------------
module lcar_datapath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lcar_pkg::dp_cmd_t                      cmd,
    output lcar_pkg::dp_status_t                   status,
    input  logic                                   data_level,
    input  logic                                   tare_request,
    input  logic                                   cfg_write,
    input  logic [lcar_pkg::IDX_W-1:0]             cfg_index,
    input  logic [lcar_pkg::SCALE_W-1:0]           cfg_data,
    output logic                                   clock_level,
    output logic                                   result_valid,
    output logic signed [lcar_pkg::NET_W-1:0]      net_counts,
    output logic signed [lcar_pkg::UNITS_W-1:0]    scaled_units,
    output logic                                   tare_done
);
    import lcar_pkg::*;

    // configuration
    logic [AVG_W-1:0]          average_count_reg;
    logic [GAIN_W-1:0]         gain_pulses_reg;
    logic signed [SCALE_W-1:0] recip_reg;

    // converter interface state
    logic                   active_reg, active_next;
    logic                   phase_reg, phase_next;
    logic [GAIN_W-1:0]      pulse_reg, pulse_next;
    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;

    // averaging state
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_W-1:0]            taken_reg, taken_next;
    logic signed [SUM_W-1:0]       offset_reg;
    logic                          pending_reg;

    // divider
    logic [SUM_W-1:0]     quo_reg;
    logic [COUNT_W-1:0]   rem_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // staged result
    logic                      res_clk_reg;
    logic                      res_valid_reg;
    logic signed [DIFF_W-1:0]  res_net_reg;
    logic                      res_done_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    // output registers
    logic                      clock_level_reg;
    logic                      result_valid_reg;
    logic signed [NET_W-1:0]   net_counts_reg;
    logic signed [UNITS_W-1:0] scaled_units_reg;
    logic                      tare_done_reg;

    logic [GAIN_W-1:0]             eff_pulses;
    logic [COUNT_W-1:0]            eff_count;
    logic                          tick_clk;
    logic                          have;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SUM_W-1:0]       sum_add;
    logic [SUM_W-1:0]              sum_mag;
    logic [COUNT_W-1:0]            taken_inc;
    logic                          need_mean;
    logic [COUNT_W:0]              rem_shift;
    logic                          rem_ge;
    logic signed [SUM_W-1:0]       mean;
    logic signed [DIFF_W-1:0]      net_value;
    logic signed [PROD_W-1:0]      prod_round;

    always_comb
    begin
        priority if (gain_pulses_reg < PULSES_MIN)
        begin
            eff_pulses = PULSES_MIN;
        end
        else if (gain_pulses_reg > PULSES_MAX)
        begin
            eff_pulses = PULSES_MAX;
        end
        else
        begin
            eff_pulses = gain_pulses_reg;
        end
    end

    always_comb
    begin
        priority if (average_count_reg == '0)
        begin
            eff_count = COUNT_W'(1);
        end
        else if (int'(average_count_reg) > MAX_AVERAGE)
        begin
            eff_count = COUNT_W'(MAX_AVERAGE);
        end
        else
        begin
            eff_count = COUNT_W'(average_count_reg);
        end
    end

    // one tick of the serial clock sequence
    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        pulse_next  = pulse_reg;
        shift_next  = shift_reg;
        tick_clk    = 1'b0;
        have        = 1'b0;
        if (!active_reg)
        begin
            if (!data_level)
            begin
                active_next = 1'b1;
                phase_next  = 1'b0;
                pulse_next  = '0;
                shift_next  = '0;
            end
        end
        else if (!phase_reg)
        begin
            tick_clk = 1'b1;
            if (pulse_reg < GAIN_W'(SAMPLE_BITS))
            begin
                shift_next = {shift_reg[SAMPLE_BITS-2:0], data_level};
            end
            phase_next = 1'b1;
        end
        else
        begin
            phase_next = 1'b0;
            pulse_next = pulse_reg + GAIN_W'(1);
            if (pulse_next >= eff_pulses)
            begin
                active_next = 1'b0;
                have        = 1'b1;
            end
        end
    end

    assign sample    = shift_reg;
    assign sum_add   = sum_reg + SUM_W'(sample);
    assign sum_mag   = sum_add[SUM_W-1] ? SUM_W'(-sum_add) : SUM_W'(sum_add);
    assign taken_inc = taken_reg + COUNT_W'(1);
    assign need_mean = have && !tare_request && (taken_inc >= eff_count);

    always_comb
    begin
        sum_next   = sum_reg;
        taken_next = taken_reg;
        if (tare_request || need_mean)
        begin
            sum_next   = '0;
            taken_next = '0;
        end
        else if (have)
        begin
            sum_next   = sum_add;
            taken_next = taken_inc;
        end
    end

    // restoring division, one quotient bit a cycle
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, eff_count};

    assign mean      = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);
    assign net_value = DIFF_W'(mean) - DIFF_W'(offset_reg);

    assign prod_round = prod_reg + PROD_W'(1 << (ROUND_SH - 1));

    assign status.need_mean = need_mean;
    assign status.div_last  = (div_cnt_reg == DIV_CNT_W'(SUM_W - 1));
    assign status.tare_mean = pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            average_count_reg <= AVG_W'(1);
            gain_pulses_reg   <= PULSES_MIN;
            recip_reg         <= '0;
            active_reg        <= 1'b0;
            phase_reg         <= 1'b0;
            pulse_reg         <= '0;
            shift_reg         <= '0;
            sum_reg           <= '0;
            taken_reg         <= '0;
            offset_reg        <= '0;
            pending_reg       <= 1'b0;
            div_cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_AVERAGE_COUNT:    average_count_reg <= cfg_data[AVG_W-1:0];
                    REG_GAIN_PULSES:      gain_pulses_reg   <= cfg_data[GAIN_W-1:0];
                    REG_RECIPROCAL_SCALE: recip_reg         <= $signed(cfg_data);
                    default:              recip_reg         <= recip_reg;
                endcase
            end
            if (cmd.tick)
            begin
                active_reg  <= active_next;
                phase_reg   <= phase_next;
                pulse_reg   <= pulse_next;
                shift_reg   <= shift_next;
                sum_reg     <= sum_next;
                taken_reg   <= taken_next;
                div_cnt_reg <= '0;
                if (tare_request)
                begin
                    pending_reg <= 1'b1;
                end
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.mean && pending_reg)
            begin
                offset_reg  <= mean;
                pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            quo_reg       <= sum_mag;
            rem_reg       <= '0;
            neg_reg       <= sum_add[SUM_W-1];
            res_clk_reg   <= tick_clk;
            res_valid_reg <= 1'b0;
            res_net_reg   <= '0;
            res_done_reg  <= 1'b0;
            prod_reg      <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? COUNT_W'(rem_shift - {1'b0, eff_count})
                              : COUNT_W'(rem_shift);
        end
        if (cmd.mean)
        begin
            if (pending_reg)
            begin
                res_done_reg <= 1'b1;
            end
            else
            begin
                res_valid_reg <= 1'b1;
                res_net_reg   <= net_value;
            end
        end
        if (cmd.mult)
        begin
            prod_reg <= res_net_reg * recip_reg;
        end
        if (cmd.load_out)
        begin
            clock_level_reg  <= res_clk_reg;
            result_valid_reg <= res_valid_reg;
            net_counts_reg   <= res_net_reg[NET_W-1:0];
            scaled_units_reg <= prod_round[ROUND_SH+UNITS_W-1:ROUND_SH];
            tare_done_reg    <= res_done_reg;
        end
    end

    assign clock_level  = clock_level_reg;
    assign result_valid = result_valid_reg;
    assign net_counts   = net_counts_reg;
    assign scaled_units = scaled_units_reg;
    assign tare_done    = tare_done_reg;

endmodule
